[rtl/chol_pkg.sv]
// Shared types and helpers for the lower Cholesky factor block.
// Used by chol_rootdiv and cholesky_lower_factor; depends on nothing else.
`timescale 1ns / 1ps
package chol_pkg;

	localparam int ADDR_W = 6;   // row/column store address, 3 + 3 bits
	localparam int IDX_W  = 3;   // row and column index width
	localparam int SIZE_W = 4;   // order register width

	typedef enum logic [1:0] {
		OP_SQRT = 2'b01,
		OP_DIV  = 2'b10
	} arith_op_t;

	// request to the shared root/divide unit
	typedef struct packed {
		logic              go;
		arith_op_t         op;
		logic signed [31:0] num;   // radicand or dividend
		logic [31:0]       den;    // divisor (pivot, always positive)
	} arith_req_t;

	// clamp a wide signed sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/cholesky_lower_factor.sv]
// Lower Cholesky factor of a small fixed-point matrix: top level.
// Depends on chol_pkg and chol_rootdiv.
`timescale 1ns / 1ps
// The block takes n*n elements (n from cfg_data, 0 acts as 1, above MAX_SIZE
// as MAX_SIZE) row-major, one per cycle while busy is low; the last element
// raises busy. A size write is taken only in a cycle with start low, so an
// element transfer and a size write never share an edge. Factoring runs column
// by column over a dual-copy store with registered reads: each entry of column j
// is first reduced over the j earlier columns, then the shared root/divide unit
// takes the square root of the pivot and divides each entry below it by that
// root (one quotient bit per cycle). The factor then streams out one entry
// per cycle, n(n+1)/2 strobes, with no way for the receiver to stall; a
// non-positive pivot gives one failure strobe instead.
module cholesky_lower_factor #(
	parameter int MAX_SIZE  = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [31:0]            element_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [chol_pkg::SIZE_W-1:0]   cfg_data,
	output logic                          result_strobe,
	output logic signed [31:0]            factor_value,
	output logic [chol_pkg::IDX_W-1:0]    row_index,
	output logic [chol_pkg::IDX_W-1:0]    col_index,
	output logic                          status,
	output logic [chol_pkg::IDX_W-1:0]    failed_column,
	output logic                          last_result
);
	import chol_pkg::*;

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_ISSUE = 6'b000010,
		S_DRAIN = 6'b000100,
		S_CALC  = 6'b001000,
		S_EMIT  = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SIZE_W-1:0]   n_use;
	logic [IDX_W-1:0]    nm1;
	logic [IDX_W-1:0]    ld_r_q, ld_c_q;
	logic [IDX_W-1:0]    col_q, row_q, sp_q;
	logic [IDX_W-1:0]    er_q, ec_q;

	// two identical copies give two reads per cycle
	logic [31:0]         mem_a [DEPTH];
	logic [31:0]         mem_b [DEPTH];
	logic [ADDR_W-1:0]   addr_a, addr_b, wr_addr;
	logic                wr_en;
	logic [31:0]         wr_data;
	logic [31:0]         rd_a_q, rd_b_q;

	logic                v_s1, base_s1, v_s2;
	logic signed [63:0]  prod_s2;
	logic signed [63:0]  acc_q;
	logic signed [31:0]  red_sat;
	logic [31:0]         piv_q;

	logic                out_v_q, out_fail_q, out_last_q;
	logic [IDX_W-1:0]    out_row_q, out_col_q, out_fc_q;

	arith_req_t          areq;
	logic                a_done;
	logic signed [31:0]  a_res;

	logic                in_xfer, cfg_xfer, pipe_empty, issue_a;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_SIZE) + ADDR_W'(c);
	endfunction

	// order in use, clamped
	always_comb begin
		if (size_q == '0) begin
			n_use = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			n_use = SIZE_W'(MAX_SIZE);
		end else begin
			n_use = size_q;
		end
		nm1 = IDX_W'(n_use - SIZE_W'(1));
	end

	assign busy       = state_q != S_LOAD;
	assign cfg_ready  = (state_q == S_LOAD) && !start;
	assign in_xfer    = start && !busy;
	assign cfg_xfer   = cfg_valid && cfg_ready;
	assign pipe_empty = !v_s1 && !v_s2;
	assign red_sat    = sat32(acc_q);

	// read addresses: base entry first, then row pairs for k = sp-1
	always_comb begin
		issue_a = 1'b0;
		addr_a  = cell_addr(row_q, col_q);
		addr_b  = cell_addr(col_q, sp_q - IDX_W'(1));
		case (state_q)
			S_ISSUE: begin
				issue_a = 1'b1;
				if (sp_q != '0) begin
					addr_a = cell_addr(row_q, sp_q - IDX_W'(1));
				end
			end
			S_EMIT: begin
				addr_a = cell_addr(er_q, ec_q);
			end
			default: begin
				issue_a = 1'b0;
			end
		endcase
	end

	// single write port shared by load and column update
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cell_addr(ld_r_q, ld_c_q);
		wr_data = element_value;
		if (state_q == S_LOAD) begin
			wr_en = in_xfer;
		end else if (state_q == S_CALC) begin
			wr_en   = a_done;
			wr_addr = cell_addr(row_q, col_q);
			wr_data = a_res;
		end
	end

	// column j entries are written only after all reads that need them,
	// so the store needs no forwarding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_a[addr_a];
		rd_b_q <= mem_b[addr_b];
	end

	// reduction datapath: multiply, then subtract floored product
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(rd_a_q) * $signed(rd_b_q);
		if (v_s1 && base_s1) begin
			acc_q <= {{32{rd_a_q[31]}}, rd_a_q};
		end else if (v_s2) begin
			acc_q <= acc_q - (prod_s2 >>> FRAC_BITS);
		end
		if (state_q == S_CALC && a_done && row_q == col_q) begin
			piv_q <= a_res;
		end
	end

	// arithmetic unit request
	always_comb begin
		areq.go  = (state_q == S_DRAIN) && pipe_empty &&
			((row_q != col_q) || (red_sat > 32'sd0));
		areq.op  = (row_q == col_q) ? OP_SQRT : OP_DIV;
		areq.num = red_sat;
		areq.den = piv_q;
	end

	chol_rootdiv #(
		.FRAC_BITS(FRAC_BITS)
	) u_rootdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (areq),
		.done  (a_done),
		.result(a_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			size_q     <= SIZE_W'(8);
			ld_r_q     <= '0;
			ld_c_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
			sp_q       <= '0;
			er_q       <= '0;
			ec_q       <= '0;
			v_s1       <= 1'b0;
			base_s1    <= 1'b0;
			v_s2       <= 1'b0;
			out_v_q    <= 1'b0;
			out_fail_q <= 1'b0;
			out_last_q <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_fc_q   <= '0;
		end else begin
			v_s1    <= issue_a;
			base_s1 <= issue_a && (sp_q == '0);
			v_s2    <= v_s1 && !base_s1;
			out_v_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (cfg_xfer) begin
						size_q <= cfg_data;
						ld_r_q <= '0;
						ld_c_q <= '0;
					end else if (in_xfer) begin
						if (ld_c_q == nm1) begin
							ld_c_q <= '0;
							if (ld_r_q == nm1) begin
								ld_r_q  <= '0;
								col_q   <= '0;
								row_q   <= '0;
								sp_q    <= '0;
								state_q <= S_ISSUE;
							end else begin
								ld_r_q <= ld_r_q + IDX_W'(1);
							end
						end else begin
							ld_c_q <= ld_c_q + IDX_W'(1);
						end
					end
				end
				S_ISSUE: begin
					if (sp_q == col_q) begin
						state_q <= S_DRAIN;
					end else begin
						sp_q <= sp_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (pipe_empty) begin
						if (row_q == col_q && red_sat <= 32'sd0) begin
							// pivot not positive: one failure transfer
							out_v_q    <= 1'b1;
							out_fail_q <= 1'b1;
							out_last_q <= 1'b1;
							out_row_q  <= '0;
							out_col_q  <= '0;
							out_fc_q   <= col_q;
							state_q    <= S_LOAD;
						end else begin
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					if (a_done) begin
						sp_q <= '0;
						if (row_q == nm1) begin
							if (col_q == nm1) begin
								er_q    <= '0;
								ec_q    <= '0;
								state_q <= S_EMIT;
							end else begin
								col_q   <= col_q + IDX_W'(1);
								row_q   <= col_q + IDX_W'(1);
								state_q <= S_ISSUE;
							end
						end else begin
							row_q   <= row_q + IDX_W'(1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_EMIT: begin
					out_v_q    <= 1'b1;
					out_fail_q <= 1'b0;
					out_fc_q   <= '0;
					out_row_q  <= er_q;
					out_col_q  <= ec_q;
					out_last_q <= (er_q == nm1) && (ec_q == er_q);
					if (ec_q == er_q) begin
						ec_q <= '0;
						if (er_q == nm1) begin
							state_q <= S_FLUSH;
						end else begin
							er_q <= er_q + IDX_W'(1);
						end
					end else begin
						ec_q <= ec_q + IDX_W'(1);
					end
				end
				S_FLUSH: begin
					state_q <= S_LOAD;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign result_strobe = out_v_q;
	assign factor_value  = out_fail_q ? 32'sd0 : $signed(rd_a_q);
	assign row_index     = out_row_q;
	assign col_index     = out_col_q;
	assign status        = out_fail_q;
	assign failed_column = out_fc_q;
	assign last_result   = out_last_q;

	// a failure transfer is always the final one
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_fail_q) |-> out_last_q)
		else $error("failure result without last flag");

	// the unit only finishes while the sequencer waits for it
	a_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		a_done |-> (state_q == S_CALC))
		else $error("arithmetic result outside calc state");

	// factor entries come only from the emit sweep
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_fail_q) |-> $past(state_q == S_EMIT))
		else $error("factor transfer not preceded by emit read");

	// reduction pipeline is idle whenever a new column step is requested
	a_req_empty: assert property (@(posedge clk) disable iff (!arst_n)
		areq.go |-> (!v_s1 && !v_s2))
		else $error("unit started with reduction in flight");

endmodule

[rtl/chol_rootdiv.sv]
// Iterative truncated square root and saturating fixed-point divide.
// One result bit per cycle; depends on chol_pkg.
`timescale 1ns / 1ps
module chol_rootdiv #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  chol_pkg::arith_req_t      req,
	output logic                      done,
	output logic signed [31:0]        result
);
	import chol_pkg::*;

	localparam int NUM_W      = 33 + FRAC_BITS;   // shifted magnitude of dividend
	localparam int SQRT_STEPS = 32;
	localparam int CNT_W      = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	arith_op_t         op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [63:0]       rad_q;
	logic [63:0]       root_q;
	logic [63:0]       bit_q;
	logic [NUM_W-1:0]  dvd_q;
	logic [NUM_W-1:0]  quo_q;
	logic [32:0]       rem_q;
	logic [31:0]       den_q;
	logic              neg_q;
	logic signed [31:0] result_q;

	logic [63:0]       root_try;
	logic              root_ge;
	logic [63:0]       root_nx;
	logic [32:0]       rem_sh;
	logic              rem_ge;
	logic [NUM_W-1:0]  quo_fin;
	logic              quo_hi;
	logic signed [31:0] div_res;
	logic              last_step;
	logic [32:0]       mag;

	// one step of each recurrence
	always_comb begin
		root_try  = root_q + bit_q;
		root_ge   = rad_q >= root_try;
		root_nx   = root_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
		rem_sh    = {rem_q[31:0], dvd_q[NUM_W-1]};
		rem_ge    = rem_sh >= {1'b0, den_q};
		quo_fin   = {quo_q[NUM_W-2:0], rem_ge};
		quo_hi    = |quo_fin[NUM_W-1:32];
		last_step = cnt_q == CNT_W'(1);
		mag       = req.num[31] ? (33'd0 - {1'b1, req.num}) : {1'b0, req.num};
	end

	// saturate the quotient to the signed range
	always_comb begin
		if (neg_q) begin
			if (quo_hi || (quo_fin[31] && (|quo_fin[30:0]))) begin
				div_res = 32'sh8000_0000;
			end else begin
				div_res = 32'sd0 - $signed(quo_fin[31:0]);
			end
		end else begin
			if (quo_hi || quo_fin[31]) begin
				div_res = 32'sh7FFF_FFFF;
			end else begin
				div_res = $signed(quo_fin[31:0]);
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.go) begin
			op_q   <= req.op;
			rad_q  <= {32'd0, req.num} << FRAC_BITS;
			root_q <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
			dvd_q  <= NUM_W'(mag) << FRAC_BITS;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= req.den;
			neg_q  <= req.num[31];
		end else if (busy_q) begin
			if (root_ge) begin
				rad_q <= rad_q - root_try;
			end
			root_q <= root_nx;
			bit_q  <= bit_q >> 2;
			rem_q  <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q  <= quo_fin;
			dvd_q  <= dvd_q << 1;
			if (last_step) begin
				result_q <= (op_q == OP_SQRT) ? $signed(root_nx[31:0]) : div_res;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
